### rtl/core/psu_pkg.sv
// psu_pkg: shared types and constants of the png scanline pixel unpacker
// used by psu_issue, psu_result and the top level of rtl/core; depends on nothing

package psu_pkg;

	localparam int LINE_W   = 14;
	localparam int CFG_W    = 14;
	localparam int CIDX_W   = 2;
	localparam int RGB_W    = 24;

	// register indexes of the configuration port
	localparam logic [CIDX_W-1:0] REG_COLOR_TYPE      = 2'd0;
	localparam logic [CIDX_W-1:0] REG_BIT_DEPTH       = 2'd1;
	localparam logic [CIDX_W-1:0] REG_LINE_WIDTH      = 2'd2;
	localparam logic [CIDX_W-1:0] REG_PALETTE_ENTRIES = 2'd3;

	// colour types
	localparam logic [2:0] CT_GRAY       = 3'd0;
	localparam logic [2:0] CT_RGB        = 3'd2;
	localparam logic [2:0] CT_PALETTE    = 3'd3;
	localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
	localparam logic [2:0] CT_RGBA       = 3'd6;

	// input functions
	localparam logic FUNC_DATA      = 1'b0;
	localparam logic FUNC_PAL_WRITE = 1'b1;

	// error codes
	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_PAL   = 2'd1;
	localparam logic [1:0] ERR_UNSUP = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic [2:0]  color_type;
		logic [3:0]  bit_depth;
		logic [13:0] line_width;
		logic [8:0]  palette_entries;
	} cfg_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       use_pal;
		logic       pal_vld;
		logic       line_end;
		logic       last;
		logic [1:0] err;
	} pix_meta_t;

endpackage

### rtl/core/psu_if.sv
// psu_if: valid/ready channel interfaces for input items and output pixels
// depends on nothing

interface psu_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  data_byte;
	logic [7:0]  palette_index;
	logic [23:0] palette_rgb;

	modport source (output valid, func, data_byte, palette_index, palette_rgb, input ready);
	modport sink (input valid, func, data_byte, palette_index, palette_rgb, output ready);
endinterface

interface psu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       line_end;
	logic       last_of_run;
	logic [1:0] error_code;

	modport source (output valid, red, green, blue, alpha, line_end, last_of_run, error_code,
		input ready);
	modport sink (input valid, red, green, blue, alpha, line_end, last_of_run, error_code,
		output ready);
endinterface

### rtl/core/psu_ram.sv
// psu_ram: generic single write port, single read port ram with registered read
// depends on nothing

module psu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/psu_issue.sv
// psu_issue: input register, sub-byte unpacking, sample assembly and line position
// depends on psu_pkg and psu_if; drives the palette ram and the result stage

module psu_issue #(
	parameter int MAX_LINE_PIXELS = 8192,
	parameter int PALETTE_DEPTH   = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  psu_pkg::cfg_t                    cfg,
	input  logic                             restart,
	psu_in_if.sink                           items,
	input  logic                             take,
	output logic                             emit,
	output psu_pkg::pix_meta_t               meta,
	output logic                             pal_wr_en,
	output logic [$clog2(PALETTE_DEPTH)-1:0] pal_wr_addr,
	output logic [psu_pkg::RGB_W-1:0]        pal_wr_data,
	output logic                             pal_rd_en,
	output logic [$clog2(PALETTE_DEPTH)-1:0] pal_rd_addr
);

	localparam int AW    = $clog2(PALETTE_DEPTH);
	localparam int PIX_W = $clog2(MAX_LINE_PIXELS + 1);
	localparam int CW    = (PIX_W > psu_pkg::LINE_W) ? PIX_W : psu_pkg::LINE_W;

	logic                      s0_valid_q;
	logic                      func_q;
	logic [7:0]                byte_q;
	logic [7:0]                pidx_q;
	logic [psu_pkg::RGB_W-1:0] prgb_q;
	logic [2:0]                pos_q;
	logic [PIX_W-1:0]          pil_q;
	logic [23:0]               sbuf_q;
	logic [1:0]                scnt_q;
	logic [PALETTE_DEPTH-1:0]  pal_vld_q;

	logic [CW-1:0]   eff_width;
	logic [CW-1:0]   pil_next;
	logic            le;
	logic [8:0]      limit;
	logic [2:0]      sh;
	logic [7:0]      shifted;
	logic [7:0]      v;
	logic            last_pos;
	logic [2:0]      need;
	logic            complete;
	logic            is_sub;
	logic            is_multi;
	logic            emits;
	logic            consume;
	logic            advance;
	logic            step;
	logic            accept;

	assign eff_width = (cfg.line_width == '0) ? CW'(1) :
		((CW'(cfg.line_width) > CW'(MAX_LINE_PIXELS)) ? CW'(MAX_LINE_PIXELS) :
		CW'(cfg.line_width));
	assign pil_next = CW'(pil_q) + CW'(1);
	assign le       = (pil_next >= eff_width);
	assign limit    = (cfg.palette_entries > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) :
		cfg.palette_entries;

	assign is_sub   = (cfg.color_type == psu_pkg::CT_GRAY) ||
		(cfg.color_type == psu_pkg::CT_PALETTE);
	assign is_multi = (cfg.color_type == psu_pkg::CT_RGB) ||
		(cfg.color_type == psu_pkg::CT_GRAY_ALPHA) || (cfg.color_type == psu_pkg::CT_RGBA);

	always_comb begin
		priority case (cfg.bit_depth)
			4'd1: begin
				sh       = pos_q;
				last_pos = (pos_q == 3'd7);
			end
			4'd2: begin
				sh       = {pos_q[1:0], 1'b0};
				last_pos = (pos_q == 3'd3);
			end
			4'd4: begin
				sh       = {pos_q[0], 2'b00};
				last_pos = (pos_q == 3'd1);
			end
			default: begin
				sh       = 3'd0;
				last_pos = 1'b1;
			end
		endcase
	end

	assign shifted = byte_q << sh;

	always_comb begin
		priority case (cfg.bit_depth)
			4'd1:    v = {7'd0, shifted[7]};
			4'd2:    v = {6'd0, shifted[7:6]};
			4'd4:    v = {4'd0, shifted[7:4]};
			default: v = shifted;
		endcase
	end

	always_comb begin
		priority if (cfg.color_type == psu_pkg::CT_RGB) begin
			need = 3'd3;
		end else if (cfg.color_type == psu_pkg::CT_GRAY_ALPHA) begin
			need = 3'd2;
		end else begin
			need = 3'd4;
		end
	end
	assign complete = ({1'b0, scnt_q} + 3'd1) >= need;

	always_comb begin
		meta          = '0;
		meta.a        = psu_pkg::ALPHA_OPAQUE;
		meta.err      = psu_pkg::ERR_OK;
		meta.line_end = 1'b0;
		meta.last     = 1'b1;
		emits         = 1'b1;
		consume       = 1'b1;
		advance       = 1'b0;
		if (func_q == psu_pkg::FUNC_PAL_WRITE) begin
			emits = 1'b0;
		end else if (is_sub) begin
			advance       = 1'b1;
			meta.line_end = le;
			meta.last     = le || last_pos;
			consume       = le || last_pos;
			if (cfg.color_type == psu_pkg::CT_GRAY) begin
				meta.r = v;
				meta.g = v;
				meta.b = v;
			end else if ({1'b0, v} < limit) begin
				meta.use_pal = 1'b1;
				meta.pal_vld = pal_vld_q[v[AW-1:0]];
			end else begin
				meta.err = psu_pkg::ERR_PAL;
			end
		end else if (is_multi) begin
			emits         = complete;
			advance       = complete;
			meta.line_end = le;
			priority if (cfg.color_type == psu_pkg::CT_RGB) begin
				meta.r = sbuf_q[15:8];
				meta.g = sbuf_q[7:0];
				meta.b = byte_q;
			end else if (cfg.color_type == psu_pkg::CT_GRAY_ALPHA) begin
				meta.r = sbuf_q[7:0];
				meta.g = sbuf_q[7:0];
				meta.b = sbuf_q[7:0];
				meta.a = byte_q;
			end else begin
				meta.r = sbuf_q[23:16];
				meta.g = sbuf_q[15:8];
				meta.b = sbuf_q[7:0];
				meta.a = byte_q;
			end
		end else begin
			meta.a   = '0;
			meta.err = psu_pkg::ERR_UNSUP;
		end
	end

	assign emit        = s0_valid_q && emits;
	assign step        = s0_valid_q && (take || !emits);
	assign items.ready = !s0_valid_q || (step && consume);
	assign accept      = items.valid && items.ready;

	assign pal_wr_en   = step && (func_q == psu_pkg::FUNC_PAL_WRITE) &&
		({1'b0, pidx_q} < 9'(PALETTE_DEPTH));
	assign pal_wr_addr = pidx_q[AW-1:0];
	assign pal_wr_data = prgb_q;
	assign pal_rd_en   = emit && take;
	assign pal_rd_addr = v[AW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= items.func;
			byte_q <= items.data_byte;
			pidx_q <= items.palette_index;
			prgb_q <= items.palette_rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
			pos_q      <= '0;
			pil_q      <= '0;
			sbuf_q     <= '0;
			scnt_q     <= '0;
			pal_vld_q  <= '0;
		end else begin
			if (accept) begin
				s0_valid_q <= 1'b1;
				pos_q      <= '0;
			end else if (step && consume) begin
				s0_valid_q <= 1'b0;
			end else if (step) begin
				pos_q <= pos_q + 3'd1;
			end
			if (pal_wr_en) begin
				pal_vld_q[pidx_q[AW-1:0]] <= 1'b1;
			end
			if (restart) begin
				pil_q  <= '0;
				sbuf_q <= '0;
				scnt_q <= '0;
			end else if (step && func_q == psu_pkg::FUNC_DATA) begin
				if (advance) begin
					pil_q <= le ? '0 : pil_next[PIX_W-1:0];
				end
				if (is_multi) begin
					if (complete) begin
						sbuf_q <= '0;
						scnt_q <= '0;
					end else begin
						sbuf_q <= {sbuf_q[15:0], byte_q};
						scnt_q <= scnt_q + 2'd1;
					end
				end
			end
		end
	end

endmodule

### rtl/core/psu_result.sv
// psu_result: result register and palette colour selection onto the pixel channel
// depends on psu_pkg and psu_if; takes registered palette data from psu_ram

module psu_result (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      emit,
	input  psu_pkg::pix_meta_t        meta,
	output logic                      take,
	input  logic [psu_pkg::RGB_W-1:0] pal_rgb,
	psu_out_if.source                 pixels
);

	logic               valid_s1;
	psu_pkg::pix_meta_t meta_s1;
	logic               pal_hit;

	assign take    = !valid_s1 || pixels.ready;
	assign pal_hit = meta_s1.use_pal && meta_s1.pal_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			meta_s1 <= meta;
		end
	end

	assign pixels.valid       = valid_s1;
	assign pixels.red         = meta_s1.use_pal ? (pal_hit ? pal_rgb[23:16] : '0) : meta_s1.r;
	assign pixels.green       = meta_s1.use_pal ? (pal_hit ? pal_rgb[15:8] : '0) : meta_s1.g;
	assign pixels.blue        = meta_s1.use_pal ? (pal_hit ? pal_rgb[7:0] : '0) : meta_s1.b;
	assign pixels.alpha       = meta_s1.a;
	assign pixels.line_end    = meta_s1.line_end;
	assign pixels.last_of_run = meta_s1.last;
	assign pixels.error_code  = meta_s1.err;

	a_err_legal: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid |-> (pixels.error_code == psu_pkg::ERR_OK ||
		pixels.error_code == psu_pkg::ERR_PAL || pixels.error_code == psu_pkg::ERR_UNSUP))
		else $error("illegal error code on pixel channel");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.line_end) |-> pixels.last_of_run)
		else $error("line end without last of run");

	a_unsup_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.error_code == psu_pkg::ERR_UNSUP) |->
		(pixels.red == '0 && pixels.alpha == '0 && pixels.last_of_run && !pixels.line_end))
		else $error("unsupported type result not blank");

	a_pal_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.error_code == psu_pkg::ERR_PAL) |->
		(pixels.red == '0 && pixels.green == '0 && pixels.blue == '0 &&
		pixels.alpha == psu_pkg::ALPHA_OPAQUE))
		else $error("palette range error pixel not opaque black");

endmodule

### rtl/core/png_scanline_pixel_unpacker.sv
// png_scanline_pixel_unpacker: top level, configuration registers and palette store
// depends on psu_pkg, psu_if, psu_ram, psu_issue and psu_result
//
// items carries one transaction per scanline byte (func 0) or palette entry write
// (func 1); pixels carries one RGBA transaction per output pixel. Both are valid/ready.
// cfg_we/cfg_index/cfg_data write color_type, bit_depth, line_width, palette_entries;
// writes are to be made while the block is idle, which it does not enforce; the first
// three restart the scanline. A byte is held in the input register and gives one pixel
// per cycle while pixels is ready: 8, 4 or 2 for gray and palette bytes at depth 1, 2
// or 4 (fewer where the line ends), one at any other depth; a multi-sample byte gives
// one only when it completes a sample, and a palette write none. The output port's
// one pixel per cycle sets this rate; a following byte is taken in the cycle its
// predecessor's last pixel moves to the result register. Input reaches pixels through
// the input register, then the result register, beside which the palette ram read is
// registered. Reset clears the configuration to gray, depth 8, width 1, 256 entries,
// clears the line position and marks every palette entry unwritten, so it reads as
// zero; no clearing pass is needed. When pixels stalls, the result register holds its
// pixel, the input register a byte that gives one; items stays not ready until it moves.

module png_scanline_pixel_unpacker #(
	parameter int MAX_LINE_PIXELS = 8192,
	parameter int PALETTE_DEPTH   = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psu_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [psu_pkg::CFG_W-1:0]   cfg_data,
	psu_in_if.sink                      items,
	psu_out_if.source                   pixels
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	psu_pkg::cfg_t             cfg_q;
	logic                      restart;
	logic                      take;
	logic                      emit;
	psu_pkg::pix_meta_t        meta;
	logic                      pal_wr_en;
	logic [AW-1:0]             pal_wr_addr;
	logic [psu_pkg::RGB_W-1:0] pal_wr_data;
	logic                      pal_rd_en;
	logic [AW-1:0]             pal_rd_addr;
	logic [psu_pkg::RGB_W-1:0] pal_rd_data;

	assign restart = cfg_we && (cfg_index == psu_pkg::REG_COLOR_TYPE ||
		cfg_index == psu_pkg::REG_BIT_DEPTH || cfg_index == psu_pkg::REG_LINE_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_type      <= psu_pkg::CT_GRAY;
			cfg_q.bit_depth       <= 4'd8;
			cfg_q.line_width      <= 14'd1;
			cfg_q.palette_entries <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psu_pkg::REG_COLOR_TYPE:      cfg_q.color_type      <= cfg_data[2:0];
				psu_pkg::REG_BIT_DEPTH:       cfg_q.bit_depth       <= cfg_data[3:0];
				psu_pkg::REG_LINE_WIDTH:      cfg_q.line_width      <= cfg_data[13:0];
				psu_pkg::REG_PALETTE_ENTRIES: cfg_q.palette_entries <= cfg_data[8:0];
			endcase
		end
	end

	psu_issue #(
		.MAX_LINE_PIXELS(MAX_LINE_PIXELS),
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_issue (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.restart(restart),
		.items(items),
		.take(take),
		.emit(emit),
		.meta(meta),
		.pal_wr_en(pal_wr_en),
		.pal_wr_addr(pal_wr_addr),
		.pal_wr_data(pal_wr_data),
		.pal_rd_en(pal_rd_en),
		.pal_rd_addr(pal_rd_addr)
	);

	psu_ram #(
		.WIDTH(psu_pkg::RGB_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk(clk),
		.wr_en(pal_wr_en),
		.wr_addr(pal_wr_addr),
		.wr_data(pal_wr_data),
		.rd_en(pal_rd_en),
		.rd_addr(pal_rd_addr),
		.rd_data(pal_rd_data)
	);

	psu_result u_result (
		.clk(clk),
		.arst_n(arst_n),
		.emit(emit),
		.meta(meta),
		.take(take),
		.pal_rgb(pal_rd_data),
		.pixels(pixels)
	);

endmodule

### bench/png_scanline_pixel_unpacker_test.sv
// png_scanline_pixel_unpacker_test: self-checking bench for the scanline pixel unpacker
// drives byte and palette-write transactions, predicts each RGBA pixel in a scoreboard
// depends on psu_pkg, psu_if and png_scanline_pixel_unpacker
`timescale 1ns / 100ps

module png_scanline_pixel_unpacker_test;

	localparam int MAX_PIXELS = 8192;
	localparam int PAL_DEPTH  = 256;

	localparam logic [2:0] CT_RESERVED_1 = 3'd1;
	localparam logic [2:0] CT_RESERVED_5 = 3'd5;
	localparam logic [2:0] CT_RESERVED_7 = 3'd7;

	typedef struct packed {
		bit [7:0] red;
		bit [7:0] green;
		bit [7:0] blue;
		bit [7:0] alpha;
		bit       line_end;
		bit       last_of_run;
		bit [1:0] error_code;
	} pixel_t;

	class pixel_scoreboard;
		bit [23:0]   palette [PAL_DEPTH];
		bit [23:0]   gathered;
		int unsigned gathered_bytes;
		int unsigned line_pos;
		bit [2:0]    color_type;
		bit [3:0]    bit_depth;
		bit [13:0]   line_width;
		bit [8:0]    pal_entries;
		pixel_t      pending [$];
		int unsigned mismatches;

		function new();
			foreach (palette[i]) palette[i] = '0;
			restart_line();
			color_type = psu_pkg::CT_GRAY;
			bit_depth = 4'd8;
			line_width = 14'd1;
			pal_entries = 9'd256;
			mismatches = 0;
		endfunction

		function void restart_line();
			gathered = '0;
			gathered_bytes = 0;
			line_pos = 0;
		endfunction

		function void write_reg(logic [psu_pkg::CIDX_W-1:0] idx,
			logic [psu_pkg::CFG_W-1:0] data);
			case (idx)
				psu_pkg::REG_COLOR_TYPE: begin
					color_type = data[2:0];
					restart_line();
				end
				psu_pkg::REG_BIT_DEPTH: begin
					bit_depth = data[3:0];
					restart_line();
				end
				psu_pkg::REG_LINE_WIDTH: begin
					line_width = data[13:0];
					restart_line();
				end
				psu_pkg::REG_PALETTE_ENTRIES: begin
					pal_entries = data[8:0];
				end
			endcase
		endfunction

		// moves to the next pixel of the line, high when the pixel just placed ends it
		function bit place_pixel();
			int unsigned span;
			span = (line_width == 0) ? 1 : (line_width > MAX_PIXELS) ? MAX_PIXELS : line_width;
			line_pos++;
			if (line_pos >= span) begin
				line_pos = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_item(logic func, logic [7:0] data, logic [7:0] pidx,
			logic [23:0] rgb);
			int unsigned depth;
			int unsigned per_byte;
			int unsigned limit;
			int unsigned need;
			int unsigned i;
			bit [7:0]    v;
			bit [23:0]   c;
			pixel_t      px;
			if (func == psu_pkg::FUNC_PAL_WRITE) begin
				palette[pidx] = rgb;
				return;
			end
			case (color_type)
				psu_pkg::CT_GRAY, psu_pkg::CT_PALETTE: begin
					depth = (bit_depth == 1 || bit_depth == 2 || bit_depth == 4) ? bit_depth : 8;
					per_byte = 8 / depth;
					limit = (pal_entries > PAL_DEPTH) ? PAL_DEPTH : pal_entries;
					for (i = 0; i < per_byte; i++) begin
						v = 8'((data >> (depth * (per_byte - 1 - i))) & ((1 << depth) - 1));
						px = '0;
						px.alpha = psu_pkg::ALPHA_OPAQUE;
						px.line_end = place_pixel();
						if (color_type == psu_pkg::CT_GRAY) begin
							px.red = v;
							px.green = v;
							px.blue = v;
						end else if (v < limit) begin
							c = palette[v];
							px.red = c[23:16];
							px.green = c[15:8];
							px.blue = c[7:0];
						end else begin
							px.error_code = psu_pkg::ERR_PAL;
						end
						// padding pixels after the end of the line are dropped
						px.last_of_run = px.line_end || (i == per_byte - 1);
						pending.push_back(px);
						if (px.line_end) break;
					end
				end
				psu_pkg::CT_RGB, psu_pkg::CT_GRAY_ALPHA, psu_pkg::CT_RGBA: begin
					need = (color_type == psu_pkg::CT_RGB) ? 3 :
						(color_type == psu_pkg::CT_GRAY_ALPHA) ? 2 : 4;
					if (gathered_bytes + 1 < need) begin
						gathered = {gathered[15:0], data};
						gathered_bytes++;
					end else begin
						px = '0;
						px.line_end = place_pixel();
						px.last_of_run = 1'b1;
						case (color_type)
							psu_pkg::CT_RGB: begin
								px.red = gathered[15:8];
								px.green = gathered[7:0];
								px.blue = data;
								px.alpha = psu_pkg::ALPHA_OPAQUE;
							end
							psu_pkg::CT_GRAY_ALPHA: begin
								px.red = gathered[7:0];
								px.green = gathered[7:0];
								px.blue = gathered[7:0];
								px.alpha = data;
							end
							default: begin
								px.red = gathered[23:16];
								px.green = gathered[15:8];
								px.blue = gathered[7:0];
								px.alpha = data;
							end
						endcase
						gathered = '0;
						gathered_bytes = 0;
						pending.push_back(px);
					end
				end
				default: begin
					// unsupported colour type: one flagged result, line position unchanged
					px = '0;
					px.last_of_run = 1'b1;
					px.error_code = psu_pkg::ERR_UNSUP;
					pending.push_back(px);
				end
			endcase
		endfunction

		function string show(pixel_t px);
			return $sformatf("rgba %02h%02h%02h%02h line_end %0b last %0b err %0d",
				px.red, px.green, px.blue, px.alpha, px.line_end, px.last_of_run,
				px.error_code);
		endfunction

		task report(string line);
			if (mismatches < 50) $display("%0t: %s", $time, line);
			mismatches++;
		endtask

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				report($sformatf("pixel with none pending: %s", show(got)));
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report($sformatf("pixel mismatch: got %s, wanted %s", show(got), show(want)));
			end
		endtask
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [psu_pkg::CIDX_W-1:0]  cfg_index;
	logic [psu_pkg::CFG_W-1:0]   cfg_data;
	bit                          calm;
	pixel_scoreboard             sb = new();

	psu_in_if  items();
	psu_out_if pixels();

	png_scanline_pixel_unpacker #(
		.MAX_LINE_PIXELS(MAX_PIXELS),
		.PALETTE_DEPTH(PAL_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.items(items),
		.pixels(pixels)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_item(input logic func, input logic [7:0] data,
		input logic [7:0] pidx, input logic [23:0] rgb);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		@(negedge clk);
		if (gap != 0) begin
			items.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.func = func;
		items.data_byte = data;
		items.palette_index = pidx;
		items.palette_rgb = rgb;
		items.valid = 1'b1;
		do @(posedge clk); while (items.ready !== 1'b1);
		sb.note_item(func, data, pidx, rgb);
	endtask

	task automatic send_data(input logic [7:0] data);
		send_item(psu_pkg::FUNC_DATA, data, 8'($urandom), 24'($urandom));
	endtask

	// wait for every pending pixel, then wait out byte-only work still in flight
	task automatic settle();
		@(negedge clk);
		items.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [psu_pkg::CIDX_W-1:0] idx,
		input logic [psu_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(input logic [psu_pkg::CFG_W-1:0] ct,
		input logic [psu_pkg::CFG_W-1:0] bd, input logic [psu_pkg::CFG_W-1:0] lw,
		input logic [psu_pkg::CFG_W-1:0] pe);
		settle();
		cfg_write(psu_pkg::REG_COLOR_TYPE, ct);
		cfg_write(psu_pkg::REG_BIT_DEPTH, bd);
		cfg_write(psu_pkg::REG_LINE_WIDTH, lw);
		cfg_write(psu_pkg::REG_PALETTE_ENTRIES, pe);
	endtask

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		pixels.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left != 0) begin
				pixels.ready = 1'b0;
				stall_left--;
			end else begin
				pixels.ready = 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && pixels.valid === 1'b1 && pixels.ready === 1'b1)
			sb.check_pixel({pixels.red, pixels.green, pixels.blue, pixels.alpha,
				pixels.line_end, pixels.last_of_run, pixels.error_code});
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [2:0]                reserved [3];
		logic [2:0]                ct;
		logic [3:0]                bd;
		logic [8:0]                pe;
		logic [psu_pkg::CFG_W-1:0] noise;
		logic [psu_pkg::CFG_W-1:0] ct_word;
		logic [psu_pkg::CFG_W-1:0] bd_word;
		logic [psu_pkg::CFG_W-1:0] pe_word;
		logic [psu_pkg::CFG_W-1:0] lw;
		int unsigned               r;
		int unsigned               sent;
		int unsigned               count;
		int unsigned               need;

		reserved = '{CT_RESERVED_1, CT_RESERVED_5, CT_RESERVED_7};
		cfg_we = 1'b0;
		cfg_index = psu_pkg::REG_COLOR_TYPE;
		cfg_data = '0;
		items.valid = 1'b0;
		items.func = psu_pkg::FUNC_DATA;
		items.data_byte = '0;
		items.palette_index = '0;
		items.palette_rgb = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: gray, depth 8, one pixel per line
		send_data(8'h00);
		send_data(8'hFF);
		send_item(psu_pkg::FUNC_PAL_WRITE, 8'h00, 8'd0, 24'hFFFFFF);
		send_item(psu_pkg::FUNC_PAL_WRITE, 8'hFF, 8'd1, 24'h0F1E2D);
		send_item(psu_pkg::FUNC_PAL_WRITE, 8'h00, 8'd255, 24'h808080);

		// palette 1 bit, one valid entry, line ends inside the second byte
		configure(psu_pkg::CT_PALETTE, 14'd1, 14'd12, 14'd1);
		send_data(8'hA5);
		send_data(8'h3C);
		// no valid entries at all
		configure(psu_pkg::CT_PALETTE, 14'd2, 14'd3, 14'd0);
		send_data(8'hE4);
		// entry count above the store size
		configure(psu_pkg::CT_PALETTE, 14'd8, 14'd2, 14'd511);
		send_data(8'hFF);
		send_data(8'h01);
		configure(psu_pkg::CT_GRAY, 14'd4, 14'd3, 14'd256);
		send_data(8'hF0);
		send_data(8'h1E);
		// odd depth acts as 8, width zero acts as one, partial pixel dropped by restart
		configure(psu_pkg::CT_RGB, 14'd3, 14'd0, 14'd256);
		send_data(8'h11);
		send_data(8'h22);
		send_data(8'h33);
		send_data(8'h44);
		configure(psu_pkg::CT_GRAY_ALPHA, 14'd15, 14'd2, 14'd256);
		send_data(8'h80);
		send_data(8'h7F);
		send_data(8'h01);
		send_data(8'hFE);
		configure(psu_pkg::CT_RGBA, 14'd0, 14'd16383, 14'd256);
		send_data(8'hDE);
		send_data(8'hAD);
		send_data(8'hBE);
		send_data(8'hEF);
		foreach (reserved[k]) begin
			configure(reserved[k], 14'd8, 14'd4, 14'd256);
			send_data(8'($urandom));
		end

		// saturated line width at 1 bit per pixel
		configure(psu_pkg::CT_GRAY, 14'd1, 14'd16383, 14'd256);
		repeat (4) send_data(8'($urandom));

		sent = 0;
		while (sent < 100) begin
			calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 2) ct = psu_pkg::CT_GRAY;
			else if (r < 5) ct = psu_pkg::CT_PALETTE;
			else if (r < 6) ct = psu_pkg::CT_RGB;
			else if (r < 7) ct = psu_pkg::CT_GRAY_ALPHA;
			else if (r < 9) ct = psu_pkg::CT_RGBA;
			else ct = reserved[$urandom_range(0, 2)];
			bd = ($urandom_range(0, 3) != 0) ? 4'(1 << $urandom_range(0, 3))
				: 4'($urandom_range(0, 15));
			lw = ($urandom_range(0, 7) != 0) ? 14'($urandom_range(1, 24))
				: 14'($urandom_range(0, 16383));
			pe = ($urandom_range(0, 4) != 0) ? 9'($urandom_range(1, 256))
				: 9'($urandom_range(0, 511));
			noise = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
			ct_word = noise;
			ct_word[2:0] = ct;
			bd_word = noise;
			bd_word[3:0] = bd;
			pe_word = noise;
			pe_word[8:0] = pe;
			configure(ct_word, bd_word, lw, pe_word);

			count = $urandom_range(6, 16);
			need = (ct == psu_pkg::CT_RGB) ? 3 : (ct == psu_pkg::CT_GRAY_ALPHA) ? 2 :
				(ct == psu_pkg::CT_RGBA) ? 4 : 1;
			// mostly whole pixels, sometimes a trailing partial one
			if (need > 1 && $urandom_range(0, 4) != 0) count = count - count % need;
			repeat (count) begin
				if ($urandom_range(0, 5) == 0)
					send_item(psu_pkg::FUNC_PAL_WRITE, 8'($urandom), 8'($urandom),
						24'($urandom));
				else
					send_data(8'($urandom));
			end
			sent += count;
		end

		settle();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
